// File: hdl/slid_pkg.sv
// Shared types and codes for the position-addressed list block.
`timescale 1ns / 1ps

package slid_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 6;
  localparam int LEN_W  = 6;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  // Broadcast to every cell of the chain in the cycle a beat is taken.
  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   pos_idx;
    logic               tap_en;
  } cell_ctrl_t;

endpackage

// File: hdl/sequential_list_insert_delete_top.sv
// Top level of the position-addressed list: control, cell chain and result stage.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+----------------------------------
//  request  | start / busy       | kind, position, value
//  result   | done (strobe)      | read_value, status, list_length
//
// One request is taken in every cycle while busy is low; busy is high only in reset.
// A request's result is registered on its way to done: first the cell chain
// shifts and captures its read tap, then the OR of all taps is registered
// with status and list_length. The receiver cannot stall; results never wait.
// Reset empties the list; the entry contents are left as they are.
`timescale 1ns / 1ps

module sequential_list_insert_delete_top #(
  parameter int CAPACITY = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind,
  input  logic [slid_pkg::POS_W-1:0]   position,
  input  logic signed [slid_pkg::WORD_W-1:0] value,
  output logic                         done,
  output logic signed [slid_pkg::WORD_W-1:0] read_value,
  output logic [1:0]                   status,
  output logic [slid_pkg::LEN_W-1:0]   list_length
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic                       accept;
  logic                       pos_in_list;
  logic                       pos_in_gap;
  slid_pkg::cell_ctrl_t       ctrl;
  slid_pkg::status_t          st_next;
  logic                       p_valid;
  slid_pkg::status_t          p_status;
  logic [slid_pkg::LEN_W-1:0] p_len;
  logic [slid_pkg::WORD_W-1:0] cell_data [CAPACITY];
  logic [slid_pkg::WORD_W-1:0] cell_tap  [CAPACITY];
  logic [slid_pkg::WORD_W-1:0] tap_or;

  assign busy   = rst;
  assign accept = start && !busy;

  assign pos_in_list = (position != '0) && (32'(position) <= 32'(count));
  assign pos_in_gap  = (position != '0) && (32'(position) <= 32'(count) + 32'd1);

  always_comb begin
    ctrl.op      = slid_pkg::CELL_HOLD;
    ctrl.pos_idx = position - slid_pkg::POS_W'(1);
    ctrl.tap_en  = 1'b0;
    st_next      = slid_pkg::ST_OK;
    count_next   = count;
    case (slid_pkg::kind_t'(kind))
      slid_pkg::KIND_READ: begin
        if (pos_in_list) begin
          ctrl.tap_en = accept;
        end else begin
          st_next = slid_pkg::ST_RANGE;
        end
      end
      slid_pkg::KIND_INSERT: begin
        if (32'(count) >= CAPACITY) begin
          st_next = slid_pkg::ST_FULL;
        end else if (!pos_in_gap) begin
          st_next = slid_pkg::ST_RANGE;
        end else begin
          ctrl.op    = accept ? slid_pkg::CELL_INSERT : slid_pkg::CELL_HOLD;
          count_next = count + CW'(1);
        end
      end
      slid_pkg::KIND_REMOVE: begin
        if (pos_in_list) begin
          ctrl.op     = accept ? slid_pkg::CELL_REMOVE : slid_pkg::CELL_HOLD;
          ctrl.tap_en = accept;
          count_next  = count - CW'(1);
        end else begin
          st_next = slid_pkg::ST_RANGE;
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  // Each cell takes its lower neighbor on insert and its upper one on remove.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slid_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .value      (value),
      .from_below (cell_data[(i == 0) ? 0 : i - 1]),
      .from_above (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // At most one tap is nonzero, so an OR picks the entry read.
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      p_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      p_valid <= accept;
      done    <= p_valid;
      if (accept) begin
        count <= count_next;
      end
    end
    p_status    <= st_next;
    p_len       <= slid_pkg::LEN_W'(count_next);
    read_value  <= tap_or;
    status      <= p_status;
    list_length <= p_len;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CAPACITY)
    else $error("entry count above capacity");

  a_done_follows_beat: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(rst, 2) |-> done == $past(accept, 2))
    else $error("result strobe does not match an accepted beat");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != slid_pkg::ST_OK |-> read_value == '0)
    else $error("error result carries a nonzero word");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(kind) != slid_pkg::KIND_CLEAR |->
      (count == $past(count) || count == $past(count) + CW'(1) ||
       count == $past(count) - CW'(1)))
    else $error("entry count moved by more than one");

endmodule

// File: hdl/slid_cell.sv
// One list entry of the shifting chain, with its read tap.
`timescale 1ns / 1ps

module slid_cell #(
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  slid_pkg::cell_ctrl_t         ctrl,
  input  logic [slid_pkg::WORD_W-1:0]  value,
  input  logic [slid_pkg::WORD_W-1:0]  from_below,
  input  logic [slid_pkg::WORD_W-1:0]  from_above,
  output logic [slid_pkg::WORD_W-1:0]  data,
  output logic [slid_pkg::WORD_W-1:0]  tap
);

  logic hit;
  logic above;

  assign hit   = (32'(ctrl.pos_idx) == INDEX);
  assign above = (32'(ctrl.pos_idx) < INDEX);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      slid_pkg::CELL_INSERT: begin
        if (hit) begin
          data <= value;
        end else if (above) begin
          data <= from_below;
        end
      end
      slid_pkg::CELL_REMOVE: begin
        if (hit || above) begin
          data <= from_above;
        end
      end
      default: begin
      end
    endcase
    // The tap captures the entry before any shift of the same beat.
    tap <= (ctrl.tap_en && hit) ? data : '0;
  end

endmodule
